@@ rtl/eisd_pkg.sv @@
// ----------------------------------------------------------------------------
// eisd_pkg: shared types and codes for the EIS multiply/divide/shift core
// Request and response payloads, the inter-stage word and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package eisd_pkg;

   localparam logic [1:0] ACT_MUL  = 2'd0;
   localparam logic [1:0] ACT_DIV  = 2'd1;
   localparam logic [1:0] ACT_ASH  = 2'd2;
   localparam logic [1:0] ACT_ASHC = 2'd3;

   // Quotient bits retired per divide stage, and the number of divide stages
   localparam int unsigned DIV_STEPS  = 8;
   localparam int unsigned DIV_STAGES = 4;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] reg_word;
      logic [15:0] pair_word;
      logic [15:0] source_word;
   } req_type;

   typedef struct packed {
      logic [15:0] result_high;
      logic [15:0] result_low;
      logic        write_high;
      logic        write_low;
      logic        flag_n;
      logic        flag_z;
      logic        flag_v;
      logic        flag_c;
   } rsp_type;

   // Word carried down the pipe
   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] reg_word;
      logic [15:0] pair_word;
      logic [31:0] res;       // multiply / shift result as {high, low}
      logic [3:0]  flags;     // N Z V C for multiply / shift
      logic        dvd_neg;
      logic        div_zero;
      logic [31:0] dvd;       // dividend magnitude, shifted out MSB first
      logic [31:0] quo;
      logic [15:0] rem;
      logic [15:0] divisor;
   } mid_type;

endpackage

`default_nettype wire

@@ rtl/eisd_front.sv @@
// ----------------------------------------------------------------------------
// eisd_front: operand decode, multiply, shifts and divide setup
// Produces the pipe word for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module eisd_front (
   input  eisd_pkg::req_type req,
   output eisd_pkg::mid_type mid
);
   import eisd_pkg::*;

   logic [5:0]         cnt;
   logic [5:0]         rcnt;
   logic [31:0]        val;
   logic signed [31:0] prod;
   logic signed [64:0] rt32;
   logic signed [48:0] rt16;
   logic [63:0]        lt32;
   logic [47:0]        lt16;
   logic [15:0]        shw;
   logic [31:0]        shp;
   logic               cw;
   logic               cp;

   always_comb begin
      cnt  = req.source_word[5:0];
      rcnt = 6'(7'd64 - {1'b0, cnt});
      val  = {req.reg_word, req.pair_word};
      prod = 32'($signed(req.reg_word) * $signed(req.source_word));
      rt32 = $signed({{32{val[31]}}, val, 1'b0}) >>> rcnt;
      rt16 = $signed({{32{req.reg_word[15]}}, req.reg_word, 1'b0}) >>> rcnt;
      lt32 = {32'b0, val} << cnt[4:0];
      lt16 = {32'b0, req.reg_word} << cnt[4:0];
      if (cnt[5]) begin
         shw = rt16[16:1];
         cw  = rt16[0];
         shp = rt32[32:1];
         cp  = rt32[0];
      end else begin
         shw = lt16[15:0];
         cw  = lt16[16];
         shp = lt32[31:0];
         cp  = lt32[32];
      end

      mid           = '0;
      mid.action    = req.action;
      mid.reg_word  = req.reg_word;
      mid.pair_word = req.pair_word;
      mid.dvd_neg   = req.reg_word[15];
      mid.div_zero  = (req.source_word == 16'd0);
      mid.dvd       = req.reg_word[15] ? 32'(-val) : val;
      mid.divisor   = req.source_word;

      unique case (req.action)
         ACT_MUL: begin
            mid.res   = prod;
            mid.flags = {prod[31], prod == 32'sd0, 1'b0,
                         !(prod[31:15] == '0 || prod[31:15] == '1)};
         end
         ACT_ASH: begin
            mid.res   = {shw, req.pair_word};
            mid.flags = {shw[15], shw == 16'd0, shw[15] ^ req.reg_word[15], cw};
         end
         ACT_ASHC: begin
            mid.res   = shp;
            mid.flags = {shp[31], shp == 32'd0, shp[31] ^ val[31], cp};
         end
         default: begin
            mid.res   = val;
            mid.flags = 4'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/eisd_div_stage.sv @@
// ----------------------------------------------------------------------------
// eisd_div_stage: one registered slice of the restoring divider
// Retires DIV_STEPS quotient bits and holds its result under backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module eisd_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  eisd_pkg::mid_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output eisd_pkg::mid_type out_data,
   input  logic              out_ready
);
   import eisd_pkg::*;

   logic    valid_ff;
   mid_type data_ff;
   mid_type data_in;
   logic [16:0] trial;

   always_comb begin
      data_in = in_data;
      trial   = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {data_in.rem, data_in.dvd[31]};
         data_in.dvd = {data_in.dvd[30:0], 1'b0};
         if (trial >= {1'b0, data_in.divisor}) begin
            data_in.rem = 16'(trial - {1'b0, data_in.divisor});
            data_in.quo = {data_in.quo[30:0], 1'b1};
         end else begin
            data_in.rem = trial[15:0];
            data_in.quo = {data_in.quo[30:0], 1'b0};
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/eisd_back.sv @@
// ----------------------------------------------------------------------------
// eisd_back: result formatting
// Applies divide signs, divide error cases and write enables.
// ----------------------------------------------------------------------------
`default_nettype none

module eisd_back (
   input  eisd_pkg::mid_type mid,
   output eisd_pkg::rsp_type rsp
);
   import eisd_pkg::*;

   logic [15:0] q16;
   logic [15:0] r16;

   always_comb begin
      q16 = mid.dvd_neg ? 16'(-mid.quo[15:0]) : mid.quo[15:0];
      r16 = mid.dvd_neg ? 16'(-mid.rem) : mid.rem;
      rsp = '0;
      rsp.result_high = mid.reg_word;
      rsp.result_low  = mid.pair_word;
      if (mid.action == ACT_DIV) begin
         priority if (mid.div_zero) begin
            rsp.flag_c = 1'b1;
         end else if (!mid.dvd_neg && mid.quo[31:16] != 16'd0) begin
            rsp.flag_v = 1'b1;
         end else begin
            rsp.result_high = q16;
            rsp.result_low  = r16;
            rsp.write_high  = 1'b1;
            rsp.write_low   = 1'b1;
            rsp.flag_n      = q16[15];
            rsp.flag_z      = (q16 == 16'd0);
         end
      end else begin
         rsp.result_high = mid.res[31:16];
         rsp.result_low  = mid.res[15:0];
         rsp.write_high  = 1'b1;
         rsp.write_low   = (mid.action != ACT_ASH);
         {rsp.flag_n, rsp.flag_z, rsp.flag_v, rsp.flag_c} = mid.flags;
      end
   end

endmodule

`default_nettype wire

@@ rtl/eis_multiply_divide_shift_core.sv @@
// ----------------------------------------------------------------------------
// eis_multiply_divide_shift_core: EIS MUL / DIV / ASH / ASHC unit
// Pipelined arithmetic unit, one transfer in and one transfer out per item.
// ----------------------------------------------------------------------------
//
//   channel   ports                        carries
//   -------   --------------------------   ----------------------------------
//   request   req_valid req_stall req_*    action, register, pair, source
//   response  rsp_valid rsp_stall rsp_*    results, write enables, N Z V C
//
// Six register stages: front (multiply, shifts, divide setup), four divide
// slices of eight quotient bits each, and the output register. One item is
// accepted every cycle when the response side keeps up. Each stage holds its
// item while the one after it is full, so bubbles close up and a stall drops
// or repeats nothing. Reset clears all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module eis_multiply_divide_shift_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eisd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eisd_pkg::rsp_type rsp_payload
);
   import eisd_pkg::*;

   // front stage
   mid_type front_mid;
   mid_type front_ff;
   logic    front_valid_ff;
   logic    front_ready;

   // divide slices: index 0 is the front stage output
   mid_type div_data  [DIV_STAGES+1];
   logic    div_valid [DIV_STAGES+1];
   logic    div_ready [DIV_STAGES+1];

   // output stage
   rsp_type back_rsp;
   rsp_type out_ff;
   logic    out_valid_ff;
   logic    out_ready;

   eisd_front u_front (
      .req (req_payload),
      .mid (front_mid)
   );

   assign front_ready = !front_valid_ff || div_ready[0];
   assign req_stall   = !front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_ready) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready && req_valid) begin
         front_ff <= front_mid;
      end
   end

   assign div_data[0]  = front_ff;
   assign div_valid[0] = front_valid_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      eisd_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_data   (div_data[g]),
         .in_ready  (div_ready[g]),
         .out_valid (div_valid[g+1]),
         .out_data  (div_data[g+1]),
         .out_ready (div_ready[g+1])
      );
   end

   eisd_back u_back (
      .mid (div_data[DIV_STAGES]),
      .rsp (back_rsp)
   );

   // output register
   assign out_ready             = !out_valid_ff || !rsp_stall;
   assign div_ready[DIV_STAGES] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= div_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid[DIV_STAGES]) begin
         out_ff <= back_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   // Only a word shift writes the high word alone
   a_low_needs_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.write_low |-> rsp_payload.write_high)
      else $error("low word written without high word");

   // A suppressed write is a divide error: exactly one of V and C, no N or Z
   a_div_error_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.write_high |->
         (rsp_payload.flag_v ^ rsp_payload.flag_c) &&
         !rsp_payload.flag_n && !rsp_payload.flag_z)
      else $error("bad flags on a suppressed write");

   // Nothing leaves the pipe right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the EIS multiply / divide / shift core
// Drives MUL, DIV, ASH and ASHC transfers with random idling on both sides,
// predicts each response and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds predicted responses in arrival order and checks each one
class eis_result_book;
   eisd_pkg::rsp_type pending[$];
   int                errors;

   // Predict a word or pair shift; returns result, sets carry
   static function automatic logic [31:0] shift_arith(logic [31:0] val, int width,
                                                     logic [15:0] src, output logic carry);
      logic [63:0] ext;
      logic [5:0]  cnt;
      int          places;
      cnt = src[5:0];
      ext = (width == 32) ? {{32{val[31]}}, val} : {{48{val[15]}}, val[15:0]};
      if (cnt[5]) begin
         places = 64 - cnt;
         carry  = ext[places - 1];
         ext    = ext >>> places;
      end else begin
         carry = (cnt == 0 || cnt > width) ? 1'b0 : ext[width - cnt];
         ext   = ext << cnt;
      end
      return (width == 32) ? ext[31:0] : {16'h0, ext[15:0]};
   endfunction

   function void note_request(eisd_pkg::req_type rq);
      eisd_pkg::rsp_type e;
      logic signed [31:0] prod, dvd;
      logic signed [63:0] quo, rmd;
      logic [31:0] pair, res;
      logic        cy;
      e = '0;
      e.result_high = rq.reg_word;
      e.result_low  = rq.pair_word;
      pair = {rq.reg_word, rq.pair_word};
      case (rq.action)
         eisd_pkg::ACT_MUL: begin
            prod = $signed(rq.reg_word) * $signed(rq.source_word);
            {e.result_high, e.result_low} = prod;
            e.write_high = 1'b1; e.write_low = 1'b1;
            e.flag_n = prod[31];
            e.flag_z = prod == 0;
            e.flag_c = (prod < -32768) || (prod > 32767);
         end
         eisd_pkg::ACT_DIV: begin
            if (rq.source_word == 0) e.flag_c = 1'b1;
            else begin
               dvd = pair;
               quo = 64'(dvd) / $signed({48'h0, rq.source_word});
               rmd = 64'(dvd) % $signed({48'h0, rq.source_word});
               if (quo >= 64'sh10000) e.flag_v = 1'b1;  // positive overflow only
               else begin
                  e.result_high = quo[15:0];
                  e.result_low  = rmd[15:0];
                  e.write_high = 1'b1; e.write_low = 1'b1;
                  e.flag_n = quo[15];
                  e.flag_z = quo[15:0] == 0;
               end
            end
         end
         eisd_pkg::ACT_ASH: begin
            res = shift_arith({16'h0, rq.reg_word}, 16, rq.source_word, cy);
            e.result_high = res[15:0];
            e.write_high = 1'b1;
            e.flag_n = res[15];
            e.flag_z = res[15:0] == 0;
            e.flag_v = res[15] ^ rq.reg_word[15];
            e.flag_c = cy;
         end
         default: begin
            res = shift_arith(pair, 32, rq.source_word, cy);
            {e.result_high, e.result_low} = res;
            e.write_high = 1'b1; e.write_low = 1'b1;
            e.flag_n = res[31];
            e.flag_z = res == 0;
            e.flag_v = res[31] ^ pair[31];
            e.flag_c = cy;
         end
      endcase
      pending.push_back(e);
   endfunction

   task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
   endtask

   task check_response(eisd_pkg::rsp_type r);
      eisd_pkg::rsp_type e;
      if (pending.size() == 0) begin
         report("unexpected response", r, 0);
         return;
      end
      e = pending.pop_front();
      if (r.result_high !== e.result_high) report("result_high", r.result_high, e.result_high);
      if (r.result_low  !== e.result_low)  report("result_low", r.result_low, e.result_low);
      if (r.write_high  !== e.write_high)  report("write_high", r.write_high, e.write_high);
      if (r.write_low   !== e.write_low)   report("write_low", r.write_low, e.write_low);
      if (r.flag_n !== e.flag_n) report("flag_n", r.flag_n, e.flag_n);
      if (r.flag_z !== e.flag_z) report("flag_z", r.flag_z, e.flag_z);
      if (r.flag_v !== e.flag_v) report("flag_v", r.flag_v, e.flag_v);
      if (r.flag_c !== e.flag_c) report("flag_c", r.flag_c, e.flag_c);
   endtask
endclass

module tb_top;
   import eisd_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1;
   rsp_type rsp_payload;

   eis_result_book book = new();
   bit      calm;       // no idling on either side while set
   int      n_mul, n_div, n_ash, n_ashc;

   eis_multiply_divide_shift_core u_dut (.*);

   always #5 clock = ~clock;

   // Response side: check at the rising edge, choose the next stall at the falling one
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) book.check_response(rsp_payload);

   always @(negedge clock)
      if (!reset) rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);

   // One request transfer; payload held until accepted, valid stays up back to back
   task send(logic [1:0] act, logic [15:0] rw, logic [15:0] pw, logic [15:0] src);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid   <= 1;
      req_payload <= '{action: act, reg_word: rw, pair_word: pw, source_word: src};
      do @(posedge clock); while (req_stall);
      book.note_request(req_payload);
      case (act)
         ACT_MUL: n_mul++;
         ACT_DIV: n_div++;
         ACT_ASH: n_ash++;
         default: n_ashc++;
      endcase
      @(negedge clock);
   endtask

   // Random operands, biased toward edge values now and then
   function automatic logic [15:0] pick_word();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task random_item();
      logic [1:0]  act;
      logic [15:0] rw, pw, src;
      act = 2'($urandom_range(3));
      rw = pick_word(); pw = pick_word(); src = pick_word();
      if (act == ACT_DIV && $urandom_range(3) != 0) begin
         // mostly quotients that fit: high word smaller in magnitude than the divisor
         src = 16'($urandom_range(1, 16'hFFFF));
         rw  = $urandom_range(1) ? 16'($urandom % src) : 16'(-($urandom % src));
      end
      if ((act == ACT_ASH || act == ACT_ASHC) && $urandom_range(1))
         src = {10'($urandom_range(1023)), 6'($urandom)};
      send(act, rw, pw, src);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes and special cases
      send(ACT_MUL, 16'h8000, 16'h0000, 16'h8000);   // largest product
      send(ACT_MUL, 16'h7FFF, 16'h0000, 16'h7FFF);
      send(ACT_MUL, 16'hFFFF, 16'h0000, 16'h8000);   // just outside word range
      send(ACT_MUL, 16'h0000, 16'hFFFF, 16'h1234);   // zero product
      send(ACT_DIV, 16'h1234, 16'h5678, 16'h0000);   // divide by zero
      send(ACT_DIV, 16'h0001, 16'h0000, 16'h0001);   // overflow
      send(ACT_DIV, 16'hFFFF, 16'hFFF9, 16'h0002);   // negative dividend
      send(ACT_DIV, 16'h8000, 16'h0000, 16'hFFFF);   // negative large quotient, truncated
      send(ACT_DIV, 16'h0000, 16'hFFFF, 16'hFFFF);
      send(ACT_ASH, 16'h8001, 16'h0000, 16'h0000);   // zero count
      send(ACT_ASH, 16'h4001, 16'h0000, 16'h0001);
      send(ACT_ASH, 16'hFFFF, 16'h0000, 16'd31);     // count beyond width
      send(ACT_ASH, 16'h8000, 16'h0000, 16'd32);     // right by 32
      send(ACT_ASH, 16'h8001, 16'h0000, 16'hFFFF);   // right by one
      send(ACT_ASH, 16'h0001, 16'h0000, 16'd16);
      send(ACT_ASHC, 16'h8000, 16'h0001, 16'h0000);
      send(ACT_ASHC, 16'h0000, 16'h0001, 16'd31);
      send(ACT_ASHC, 16'hFFFF, 16'hFFFF, 16'd32);
      send(ACT_ASHC, 16'h8000, 16'h0000, 16'd33);
      send(ACT_ASHC, 16'h7FFF, 16'hFFFF, 16'd63);

      for (int i = 0; i < 950; i++) begin
         calm = (i >= 300 && i < 420);
         random_item();
      end
      calm = 0;
      req_valid <= 0;

      while (book.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d multiplies, %0d divides, %0d word shifts, %0d pair shifts",
               n_mul, n_div, n_ash, n_ashc);
      if (book.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end
endmodule

`default_nettype wire

@@ files.f @@
rtl/eisd_pkg.sv
rtl/eisd_front.sv
rtl/eisd_div_stage.sv
rtl/eisd_back.sv
rtl/eis_multiply_divide_shift_core.sv
tb/tb_top.sv
